FILE: hdl/plen_pkg.sv
// plen_pkg: shared types and constants for the polyline length accumulator
// no dependencies; imported by plen_sqrt and polyline_length_accumulator_unit
`default_nettype none

package plen_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned TOTAL_WIDTH_DEF = 32;
  localparam int unsigned OUT_LEN_W       = 32;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQX  = 5'b00010,
    ST_SQY  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_FIN  = 5'b10000
  } plen_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

FILE: hdl/plen_sqrt.sv
// plen_sqrt: bit-serial restoring integer square root, one root bit a cycle
// depends on plen_pkg for the status struct
`default_nettype none

module plen_sqrt #(
  parameter int unsigned ROOT_W = 18
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [2*ROOT_W-1:0]     radicand_i,
  output logic      [ROOT_W-1:0]       root_o,
  output plen_pkg::sqrt_stat_t         stat_o
);
  import plen_pkg::*;

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = fits ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("root unit started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("root unit done while busy");
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(start_i))
    else $error("root unit busy without start");
`endif

endmodule

`default_nettype wire

FILE: hdl/polyline_length_accumulator_unit.sv
// polyline_length_accumulator_unit: top level, sequencer, shared squarer and accumulator
// depends on plen_pkg and plen_sqrt
//
// usage: points of a path arrive on the point channel (point_valid_i/point_ready_o)
// as signed Q8.8 x and y with last_point_i on the final point. each transaction
// after the first of a path adds floor(sqrt(dx*dx + dy*dy)) to a saturating total.
// on the last point one result transaction (path_length_o, length_saturated_o)
// is offered on the result channel and the path state is cleared.
// timing: a point is taken only while the sequencer is idle. a first point goes
// straight to the accumulate step; any other point passes through two multiply
// steps on the single shared squarer, the one-bit-per-cycle square root unit
// and the accumulate step. the result sits in an output register, so the next
// path can start while a result waits; a last point only stalls in its
// accumulate step while an earlier result is still held by the receiver.
// reset clears the path state, the sequencer and the result valid flag.
`default_nettype none

module polyline_length_accumulator_unit #(
  parameter int unsigned COORD_WIDTH = plen_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TOTAL_WIDTH = plen_pkg::TOTAL_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           point_valid_i,
  output logic                                point_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]  point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]  point_y_i,
  input  wire logic                           last_point_i,
  output logic                                result_valid_o,
  input  wire logic                           result_ready_i,
  output logic [plen_pkg::OUT_LEN_W-1:0]      path_length_o,
  output logic                                length_saturated_o
);
  import plen_pkg::*;

  localparam int unsigned MAG_W  = COORD_WIDTH + 1;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned ROOT_W = COORD_WIDTH + 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned ADD_W  = (TOTAL_WIDTH > ROOT_W ? TOTAL_WIDTH : ROOT_W) + 1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  plen_state_e st_q, st_d;

  logic [COORD_WIDTH-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                   have_prev_q, have_prev_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;
  logic                   sat_q, sat_d;
  logic                   last_q, last_d;
  logic [MAG_W-1:0]       ax_q, ax_d, ay_q, ay_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_LEN_W-1:0]   out_len_q, out_len_d;
  logic                   out_sat_q, out_sat_d;

  logic [COORD_WIDTH:0]   dx, dy;
  logic [MAG_W-1:0]       mul_a;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum_next;
  logic                   sq_start;
  logic [ROOT_W-1:0]      root;
  sqrt_stat_t             sq_stat;
  logic [ADD_W-1:0]       add_sum;
  logic                   add_ovf;
  logic [TOTAL_WIDTH-1:0] total_new;
  logic                   sat_new;
  logic                   accept;
  logic                   out_free;

  assign dx = {point_x_i[COORD_WIDTH-1], point_x_i} - {prev_x_q[COORD_WIDTH-1], prev_x_q};
  assign dy = {point_y_i[COORD_WIDTH-1], point_y_i} - {prev_y_q[COORD_WIDTH-1], prev_y_q};

  // one squarer shared by both axes
  assign mul_a    = (st_q == ST_SQX) ? ax_q : ay_q;
  assign prod     = PROD_W'(mul_a) * PROD_W'(mul_a);
  assign sum_next = sum_q + SUM_W'(prod);
  assign sq_start = (st_q == ST_SQY);

  plen_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (RAD_W'(sum_next)),
    .root_o     (root),
    .stat_o     (sq_stat)
  );

  // saturating accumulate, only when a segment was measured
  assign add_sum   = ADD_W'(total_q) + ADD_W'(root);
  assign add_ovf   = add_sum[ADD_W-1:TOTAL_WIDTH] != '0;
  assign total_new = !have_prev_q ? total_q :
                     (add_ovf ? TOTAL_MAX : add_sum[TOTAL_WIDTH-1:0]);
  assign sat_new   = sat_q | (have_prev_q & add_ovf);

  assign accept   = point_valid_i && point_ready_o;
  assign out_free = !out_valid_q || result_ready_i;

  always_comb begin
    st_d        = st_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    total_d     = total_q;
    sat_d       = sat_q;
    last_d      = last_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    sum_d       = sum_q;
    out_len_d   = out_len_q;
    out_sat_d   = out_sat_q;
    out_valid_d = out_valid_q && !result_ready_i;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          ax_d     = dx[COORD_WIDTH] ? MAG_W'(-dx) : MAG_W'(dx);
          ay_d     = dy[COORD_WIDTH] ? MAG_W'(-dy) : MAG_W'(dy);
          prev_x_d = point_x_i;
          prev_y_d = point_y_i;
          last_d   = last_point_i;
          st_d     = have_prev_q ? ST_SQX : ST_FIN;
        end
      end
      ST_SQX: begin
        sum_d = SUM_W'(prod);
        st_d  = ST_SQY;
      end
      ST_SQY: begin
        st_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          total_d     = total_new;
          sat_d       = sat_new;
          have_prev_d = 1'b1;
          st_d        = ST_IDLE;
        end else if (out_free) begin
          out_len_d   = OUT_LEN_W'(total_new);
          out_sat_d   = sat_new;
          out_valid_d = 1'b1;
          total_d     = '0;
          sat_d       = 1'b0;
          have_prev_d = 1'b0;
          prev_x_d    = '0;
          prev_y_d    = '0;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
      total_q     <= total_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    sum_q     <= sum_d;
    out_len_q <= out_len_d;
    out_sat_q <= out_sat_d;
  end

  assign point_ready_o      = (st_q == ST_IDLE);
  assign result_valid_o     = out_valid_q;
  assign path_length_o      = out_len_q;
  assign length_saturated_o = out_sat_q;

`ifndef SYNTH
  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> st_q == ST_ROOT)
    else $error("root result outside root phase");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q != ST_IDLE)
    else $error("sequencer idle after accepted transaction");
  a_fresh_path_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_prev_q |-> (total_q == '0 && !sat_q))
    else $error("total not clear at path start");
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> out_len_q == OUT_LEN_W'(TOTAL_MAX))
    else $error("saturated result not at maximum");
`endif

endmodule

`default_nettype wire
